### hw/rtl/matrix_add_sub_mul_engine_core_assert.svh
// ----------------------------------------------------------------------------
// Matrix engine assertion macros
// Property shorthands for the matrix engine core, clocked on i_clk and
// disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MATRIX_ADD_SUB_MUL_ENGINE_CORE_ASSERT_SVH
`define MATRIX_ADD_SUB_MUL_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication.
`define MASE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define MASE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/mase_pkg.sv
// ----------------------------------------------------------------------------
// Matrix engine package
// Sizes, element types, register indexes, operation codes, controller
// states and the command/status structs between controller and datapath.
// ----------------------------------------------------------------------------
package mase_pkg;

    localparam int MAX_DIM     = 8;
    localparam int ELEM_WIDTH  = 32;
    localparam int DATA_W      = 32;
    localparam int DIM_W       = 4;
    localparam int IDX_W       = $clog2(MAX_DIM);
    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int SIZE_W      = $clog2(STORE_DEPTH + 1);
    localparam int LOAD_W      = $clog2(2 * STORE_DEPTH + 1);
    localparam int OP_W        = 2;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 4;

    typedef logic [ELEM_WIDTH-1:0] t_elem;
    typedef logic [DIM_W-1:0]      t_dim;
    typedef logic [IDX_W-1:0]      t_idx;
    typedef logic [ADDR_W-1:0]     t_addr;
    typedef logic [SIZE_W-1:0]     t_size;
    typedef logic [LOAD_W-1:0]     t_load;
    typedef logic [OP_W-1:0]       t_op;
    typedef logic [CFG_ADDR_W-1:0] t_cfg_addr;

    localparam t_op OP_ADD = 2'd0;
    localparam t_op OP_SUB = 2'd1;
    localparam t_op OP_MUL = 2'd2;

    localparam t_cfg_addr CFG_OPERATION = 3'd0;
    localparam t_cfg_addr CFG_ROWS_A    = 3'd1;
    localparam t_cfg_addr CFG_COLS_A    = 3'd2;
    localparam t_cfg_addr CFG_ROWS_B    = 3'd3;
    localparam t_cfg_addr CFG_COLS_B    = 3'd4;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_ISSUE,
        ST_WAIT,
        ST_ERR
    } t_state;

    typedef struct packed {
        logic start;
        logic load_wr;
        logic issue;
        logic load_out;
        logic load_err;
    } t_dp_cmd;

    typedef struct packed {
        logic load_final;
        logic fits;
        logic dot_last;
        logic out_last;
        logic acc_done;
    } t_dp_st;

    function automatic t_dim clamp_dim(input t_dim d);
        if (d == '0) begin
            return t_dim'(1);
        end else if (d > t_dim'(MAX_DIM)) begin
            return t_dim'(MAX_DIM);
        end
        return d;
    endfunction

endpackage

### hw/rtl/mase_dp.sv
// ----------------------------------------------------------------------------
// Matrix engine datapath
// Configuration registers, element stores for A and B, load counter,
// output index counters, read / multiply / accumulate pipeline and the
// result register.
// ----------------------------------------------------------------------------
module mase_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  mase_pkg::t_cfg_addr             i_cfg_addr,
    input  logic [mase_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic signed [mase_pkg::DATA_W-1:0] i_element_value,
    input  mase_pkg::t_dp_cmd               i_cmd,
    output mase_pkg::t_dp_st                o_st,
    output logic signed [mase_pkg::DATA_W-1:0] o_result_value,
    output logic                            o_shape_error,
    output logic                            o_last_result
);
    import mase_pkg::*;

    t_op   r_op;
    t_dim  r_rows_a, r_cols_a, r_rows_b, r_cols_b;
    t_load r_load_count, n_load_count;
    t_elem r_mem_a [STORE_DEPTH];
    t_elem r_mem_b [STORE_DEPTH];

    t_idx  r_row, r_col, r_dot;
    t_elem r_rd_a, r_rd_b;
    logic  r_s1_vld, r_s1_first, r_s1_last;
    t_elem r_prod;
    logic  r_s2_vld, r_s2_first, r_s2_last;
    t_elem r_acc;
    logic  r_acc_done;
    t_elem r_res;
    logic  r_err, r_last;

    t_dim  ra, ca, rb, cb, dot_len;
    t_size size_a, size_b;
    t_load total, pos, pos_inc, pos_b;
    logic  is_mul, fits;
    t_size a_lin, b_lin;
    t_elem w_prod;

    always_comb begin
        ra      = clamp_dim(r_rows_a);
        ca      = clamp_dim(r_cols_a);
        rb      = clamp_dim(r_rows_b);
        cb      = clamp_dim(r_cols_b);
        size_a  = SIZE_W'(ra) * SIZE_W'(ca);
        size_b  = SIZE_W'(rb) * SIZE_W'(cb);
        total   = LOAD_W'(size_a) + LOAD_W'(size_b);
        pos     = (r_load_count >= total) ? '0 : r_load_count;
        pos_inc = pos + LOAD_W'(1);
        pos_b   = pos - LOAD_W'(size_a);
        is_mul  = (r_op == OP_MUL);
        dot_len = is_mul ? ca : t_dim'(1);
        if (r_op == OP_ADD || r_op == OP_SUB) begin
            fits = (ra == rb) && (ca == cb);
        end else if (is_mul) begin
            fits = (ca == rb);
        end else begin
            fits = 1'b0;
        end
        a_lin = SIZE_W'(r_row) * SIZE_W'(ca) + SIZE_W'(is_mul ? r_dot : r_col);
        b_lin = is_mul ? SIZE_W'(r_dot) * SIZE_W'(cb) + SIZE_W'(r_col) : a_lin;
        n_load_count = r_load_count;
        if (i_cmd.load_wr) begin
            n_load_count = (pos_inc >= total) ? '0 : pos_inc;
        end
        unique case (r_op)
            OP_MUL:  w_prod = ELEM_WIDTH'(r_rd_a * r_rd_b);
            OP_SUB:  w_prod = r_rd_a - r_rd_b;
            default: w_prod = r_rd_a + r_rd_b;
        endcase
    end

    always_comb begin
        o_st.load_final = (pos_inc >= total);
        o_st.fits       = fits;
        o_st.dot_last   = (r_dot == IDX_W'(dot_len - t_dim'(1)));
        o_st.out_last   = (r_row == IDX_W'(ra - t_dim'(1)))
                       && (r_col == IDX_W'(cb - t_dim'(1)));
        o_st.acc_done   = r_acc_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op         <= OP_ADD;
            r_rows_a     <= t_dim'(1);
            r_cols_a     <= t_dim'(1);
            r_rows_b     <= t_dim'(1);
            r_cols_b     <= t_dim'(1);
            r_load_count <= '0;
        end else begin
            r_load_count <= n_load_count;
            if (i_cfg_wr_en) begin
                unique case (i_cfg_addr)
                    CFG_OPERATION: r_op     <= i_cfg_wdata[OP_W-1:0];
                    CFG_ROWS_A:    r_rows_a <= i_cfg_wdata[DIM_W-1:0];
                    CFG_COLS_A:    r_cols_a <= i_cfg_wdata[DIM_W-1:0];
                    CFG_ROWS_B:    r_rows_b <= i_cfg_wdata[DIM_W-1:0];
                    CFG_COLS_B:    r_cols_b <= i_cfg_wdata[DIM_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wr) begin
            if (pos < LOAD_W'(size_a)) begin
                r_mem_a[pos[ADDR_W-1:0]] <= i_element_value[ELEM_WIDTH-1:0];
            end else begin
                r_mem_b[pos_b[ADDR_W-1:0]] <= i_element_value[ELEM_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_rd_a <= r_mem_a[a_lin[ADDR_W-1:0]];
            r_rd_b <= r_mem_b[b_lin[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row      <= '0;
            r_col      <= '0;
            r_dot      <= '0;
            r_s1_vld   <= 1'b0;
            r_s1_first <= 1'b0;
            r_s1_last  <= 1'b0;
            r_s2_vld   <= 1'b0;
            r_s2_first <= 1'b0;
            r_s2_last  <= 1'b0;
            r_acc_done <= 1'b0;
        end else begin
            r_s1_vld   <= i_cmd.issue;
            r_s1_first <= (r_dot == '0);
            r_s1_last  <= o_st.dot_last;
            r_s2_vld   <= r_s1_vld;
            r_s2_first <= r_s1_first;
            r_s2_last  <= r_s1_last;
            if (i_cmd.start) begin
                r_row <= '0;
                r_col <= '0;
                r_dot <= '0;
            end else if (i_cmd.issue) begin
                r_dot <= o_st.dot_last ? '0 : r_dot + IDX_W'(1);
            end else if (i_cmd.load_out) begin
                if (r_col == IDX_W'(cb - t_dim'(1))) begin
                    r_col <= '0;
                    r_row <= r_row + IDX_W'(1);
                end else begin
                    r_col <= r_col + IDX_W'(1);
                end
            end
            if (i_cmd.load_out) begin
                r_acc_done <= 1'b0;
            end else if (r_s2_vld && r_s2_last) begin
                r_acc_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        if (r_s2_vld) begin
            r_acc <= r_s2_first ? r_prod : r_acc + r_prod;
        end
        if (i_cmd.load_err) begin
            r_res  <= '0;
            r_err  <= 1'b1;
            r_last <= 1'b1;
        end else if (i_cmd.load_out) begin
            r_res  <= r_acc;
            r_err  <= 1'b0;
            r_last <= o_st.out_last;
        end
    end

    assign o_result_value = DATA_W'(signed'(r_res));
    assign o_shape_error  = r_err;
    assign o_last_result  = r_last;

endmodule

### hw/rtl/mase_ctrl.sv
// ----------------------------------------------------------------------------
// Matrix engine controller
// Sequences loading, the per-result dot product issue, result hand-off
// and the shape error result; owns the result valid flag.
// ----------------------------------------------------------------------------
module mase_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_ready,
    input  mase_pkg::t_dp_st  i_st,
    output mase_pkg::t_dp_cmd o_cmd
);
    import mase_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: begin
                if (i_valid && i_st.load_final) begin
                    n_state = i_st.fits ? ST_ISSUE : ST_ERR;
                end
            end
            ST_ISSUE: begin
                if (i_st.dot_last) begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (i_st.acc_done && out_free) begin
                    n_state = i_st.out_last ? ST_LOAD : ST_ISSUE;
                end
            end
            ST_ERR: begin
                if (out_free) begin
                    n_state = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    always_comb begin
        o_ready = 1'b0;
        o_cmd   = '0;
        unique case (r_state)
            ST_LOAD: begin
                o_ready       = 1'b1;
                o_cmd.load_wr = i_valid;
                o_cmd.start   = i_valid && i_st.load_final;
            end
            ST_ISSUE: begin
                o_cmd.issue = 1'b1;
            end
            ST_WAIT: begin
                o_cmd.load_out = i_st.acc_done && out_free;
            end
            ST_ERR: begin
                o_cmd.load_err = out_free;
            end
            default: ;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out || o_cmd.load_err) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid = r_out_valid;

endmodule

### hw/rtl/matrix_add_sub_mul_engine_core.sv
// ----------------------------------------------------------------------------
// Matrix add / subtract / multiply engine core
// Loads one element per cycle while o_ready is high; the last element of B
// starts the job. Each result issues cols_a products for multiply, one for
// add or subtract, into the one shared read / multiply / accumulate pipeline.
// A shape error beat is loaded in ST_ERR once the output is free. Sync reset.
// ----------------------------------------------------------------------------
module matrix_add_sub_mul_engine_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  mase_pkg::t_cfg_addr             i_cfg_addr,
    input  logic [mase_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic signed [mase_pkg::DATA_W-1:0] i_element_value,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic signed [mase_pkg::DATA_W-1:0] o_result_value,
    output logic                            o_shape_error,
    output logic                            o_last_result
);
    import mase_pkg::*;

`include "matrix_add_sub_mul_engine_core_assert.svh"

    t_dp_cmd w_cmd;
    t_dp_st  w_st;

    mase_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_st    (w_st),
        .o_cmd   (w_cmd)
    );

    mase_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_element_value (i_element_value),
        .i_cmd           (w_cmd),
        .o_st            (w_st),
        .o_result_value  (o_result_value),
        .o_shape_error   (o_shape_error),
        .o_last_result   (o_last_result)
    );

    `MASE_ASSERT_NOW(a_err_beat, o_valid && o_shape_error, o_result_value == '0 && o_last_result, "error beat must be zero and last")
    `MASE_ASSERT_NOW(a_load_slot, w_cmd.load_out || w_cmd.load_err, !o_valid || i_ready, "result loaded over a pending beat")
    `MASE_ASSERT_NOW(a_idle_clean, o_ready, !w_st.acc_done, "accumulator pending while loading")
    `MASE_ASSERT_NEXT(a_load_valid, w_cmd.load_out || w_cmd.load_err, o_valid, "loaded result not presented")

endmodule
